// File: rtl/core/assert_macros.svh
// Assertion macros of the handle table RTL, used by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/ght_pkg.sv
// Shared types and constants of the generational handle table.
package ght_pkg;

    localparam int GEN_PORT_W = 32;
    localparam int VIOL_W     = 32;
    localparam int WORD_W     = 32;
    localparam int WOFF_W     = 5;

    typedef logic [1:0] kind_t;
    typedef logic [1:0] status_t;

    localparam kind_t KIND_PIN   = 2'd0;
    localparam kind_t KIND_UNPIN = 2'd1;
    localparam kind_t KIND_DEREF = 2'd2;
    localparam kind_t KIND_BAD   = 2'd3;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_BAD_INDEX = 2'd2;
    localparam status_t ST_STALE     = 2'd3;

    typedef struct packed {
        logic search;
        logic free;
    } fm_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic found;
    } fm_stat_t;

endpackage

// File: rtl/core/ght_req_if.sv
// Request channel of the handle table: one operation word.
interface ght_req_if #(
    parameter int ADDR_W = 32,
    parameter int SLOT_W = 13
);
    logic                             valid;
    logic                             ready;
    ght_pkg::kind_t                   kind;
    logic [ADDR_W-1:0]                object_address;
    logic [SLOT_W-1:0]                handle_slot;
    logic [ght_pkg::GEN_PORT_W-1:0]   handle_generation;

    modport source (
        output valid, kind, object_address, handle_slot, handle_generation,
        input  ready
    );
    modport sink (
        input  valid, kind, object_address, handle_slot, handle_generation,
        output ready
    );
endinterface

// File: rtl/core/ght_rsp_if.sv
// Response channel of the handle table: one result word.
interface ght_rsp_if #(
    parameter int ADDR_W = 32,
    parameter int SLOT_W = 13
);
    logic                             valid;
    logic                             ready;
    ght_pkg::status_t                 status;
    logic [SLOT_W-1:0]                out_slot;
    logic [ght_pkg::GEN_PORT_W-1:0]   out_generation;
    logic [ADDR_W-1:0]                out_address;
    logic [SLOT_W-1:0]                live_count;
    logic [ght_pkg::VIOL_W-1:0]       violation_count;

    modport source (
        output valid, status, out_slot, out_generation, out_address, live_count,
               violation_count,
        input  ready
    );
    modport sink (
        input  valid, status, out_slot, out_generation, out_address, live_count,
               violation_count,
        output ready
    );
endinterface

// File: rtl/core/ght_free_map.sv
// Occupancy bitmap of the handle table with a word-at-a-time free-slot search and slot freeing.
module ght_free_map #(
    parameter int CAPACITY = 4096,
    parameter int IDX_W    = 12,
    parameter int HINT_W   = 13
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ght_pkg::fm_ctrl_t     ctrl,
    input  logic [HINT_W-1:0]     hint,
    input  logic [IDX_W-1:0]      free_idx,
    output ght_pkg::fm_stat_t     stat,
    output logic [IDX_W-1:0]      found_idx
);

    localparam int WORDS   = (CAPACITY + ght_pkg::WORD_W - 1) / ght_pkg::WORD_W;
    localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FULL_W  = WADDR_W + ght_pkg::WOFF_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE
    } state_t;

    state_t                         state_reg;
    logic [WADDR_W-1:0]             clr_reg;
    logic [WADDR_W-1:0]             word_reg;
    logic [ght_pkg::WOFF_W-1:0]     off_reg;
    logic                           first_reg;
    logic [ght_pkg::WOFF_W-1:0]     free_off_reg;
    logic                           done_reg;
    logic                           found_reg;
    logic [IDX_W-1:0]               idx_reg;
    logic                           done_next;
    logic                           found_next;

    logic [ght_pkg::WORD_W-1:0]     map_mem [WORDS];
    logic [ght_pkg::WORD_W-1:0]     rd_data_reg;

    logic                           rd_en;
    logic [WADDR_W-1:0]             rd_addr;
    logic                           wr_en;
    logic [WADDR_W-1:0]             wr_addr;
    logic [ght_pkg::WORD_W-1:0]     wr_data;

    logic [FULL_W-1:0]              hint_full;
    logic [FULL_W-1:0]              free_full;
    logic [WADDR_W-1:0]             hint_word;
    logic [WADDR_W-1:0]             free_word;
    logic                           hint_out;
    logic [ght_pkg::WORD_W-1:0]     cand;
    logic [ght_pkg::WOFF_W-1:0]     pick;
    logic                           any;
    logic                           last_word;

    assign hint_full = FULL_W'(hint);
    assign free_full = FULL_W'(free_idx);
    assign hint_word = hint_full[FULL_W-1:ght_pkg::WOFF_W];
    assign free_word = free_full[FULL_W-1:ght_pkg::WOFF_W];
    assign hint_out  = (hint >= HINT_W'(CAPACITY));
    assign last_word = (word_reg == WADDR_W'(WORDS - 1));

    always_comb
    begin
        cand = '0;
        for (int b = 0; b < ght_pkg::WORD_W; b++)
        begin
            cand[b] = !rd_data_reg[b]
                && (!first_reg || (ght_pkg::WOFF_W'(b) >= off_reg))
                && ({1'b0, word_reg, ght_pkg::WOFF_W'(b)} < (FULL_W + 1)'(CAPACITY));
        end
    end

    always_comb
    begin
        pick = '0;
        for (int b = ght_pkg::WORD_W - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                pick = ght_pkg::WOFF_W'(b);
            end
        end
    end

    assign any = |cand;

    assign found_next = (state_reg == S_SCAN) && any;
    assign done_next  = found_next || ((state_reg == S_SCAN) && last_word)
                        || ((state_reg == S_IDLE) && ctrl.search && hint_out);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = word_reg;
        wr_en   = 1'b0;
        wr_addr = word_reg;
        wr_data = rd_data_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
            end
            S_IDLE:
            begin
                if (ctrl.search && !hint_out)
                begin
                    rd_en   = 1'b1;
                    rd_addr = hint_word;
                end
                else if (ctrl.free)
                begin
                    rd_en   = 1'b1;
                    rd_addr = free_word;
                end
            end
            S_SCAN:
            begin
                if (any)
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_reg | (ght_pkg::WORD_W'(1) << pick);
                end
                else if (!last_word)
                begin
                    rd_en   = 1'b1;
                    rd_addr = word_reg + WADDR_W'(1);
                end
            end
            S_FREE:
            begin
                wr_en   = 1'b1;
                wr_data = rd_data_reg & ~(ght_pkg::WORD_W'(1) << free_off_reg);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= done_next;
            found_reg <= found_next;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + WADDR_W'(1);
                    if (clr_reg == WADDR_W'(WORDS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (ctrl.search)
                    begin
                        if (!hint_out)
                        begin
                            word_reg  <= hint_word;
                            off_reg   <= hint_full[ght_pkg::WOFF_W-1:0];
                            first_reg <= 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                    else if (ctrl.free)
                    begin
                        word_reg     <= free_word;
                        free_off_reg <= free_full[ght_pkg::WOFF_W-1:0];
                        state_reg    <= S_FREE;
                    end
                end
                S_SCAN:
                begin
                    if (any)
                    begin
                        idx_reg   <= IDX_W'({word_reg, pick});
                        state_reg <= S_IDLE;
                    end
                    else if (last_word)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        word_reg  <= word_reg + WADDR_W'(1);
                        first_reg <= 1'b0;
                    end
                end
                S_FREE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stat.busy  = (state_reg != S_IDLE);
    assign stat.done  = done_reg;
    assign stat.found = found_reg;
    assign found_idx  = idx_reg;

endmodule

// File: rtl/core/generational_handle_table_top.sv
// Generational handle table: slot memory, sequencer and result register.
// Pin searches the bitmap word by word from the hint and then writes the found slot.
// A hint past the end ends the search at once. Unpin and dereference use the slot memory read port.
// Rejected operations go straight to the result; one operation is in work at a time.
// A result that the sink has not taken holds the next result, and the sequencer, in the done state.
// After reset a clearing pass writes every slot; ready stays low until it and the bitmap clear are done.
`include "assert_macros.svh"

module generational_handle_table_top #(
    parameter int CAPACITY   = 4096,
    parameter int ADDR_WIDTH = 32,
    parameter int GEN_WIDTH  = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    ght_req_if.sink      req,
    ght_rsp_if.source    rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = GEN_WIDTH + ADDR_WIDTH;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_CLR_WAIT,
        S_IDLE,
        S_FM_START,
        S_SEARCH,
        S_PIN_WR,
        S_LOOKUP,
        S_DONE
    } state_t;

    state_t                           state_reg;
    logic [IDX_W-1:0]                 clr_reg;
    ght_pkg::kind_t                   kind_reg;
    logic [ADDR_WIDTH-1:0]            addr_in_reg;
    logic [IDX_W-1:0]                 idx_reg;
    logic [ght_pkg::GEN_PORT_W-1:0]   hgen_reg;
    logic [CNT_W-1:0]                 hint_reg;
    logic [CNT_W-1:0]                 live_reg;
    logic [ght_pkg::VIOL_W-1:0]       stale_reg;

    ght_pkg::status_t                 res_status_reg;
    logic [CNT_W-1:0]                 res_slot_reg;
    logic [ght_pkg::GEN_PORT_W-1:0]   res_gen_reg;
    logic [ADDR_WIDTH-1:0]            res_addr_reg;

    logic                             rsp_valid_reg;
    logic                             rsp_valid_next;
    logic                             rsp_load;
    ght_pkg::status_t                 rsp_status_reg;
    logic [CNT_W-1:0]                 rsp_slot_reg;
    logic [ght_pkg::GEN_PORT_W-1:0]   rsp_gen_reg;
    logic [ADDR_WIDTH-1:0]            rsp_addr_reg;
    logic [CNT_W-1:0]                 rsp_live_reg;
    logic [ght_pkg::VIOL_W-1:0]       rsp_viol_reg;

    logic [ENT_W-1:0]                 ent_mem [CAPACITY];
    logic [ENT_W-1:0]                 ent_rd_reg;

    logic                             mem_re;
    logic [IDX_W-1:0]                 mem_raddr;
    logic                             mem_we;
    logic [IDX_W-1:0]                 mem_waddr;
    logic [ENT_W-1:0]                 mem_wdata;

    logic [GEN_WIDTH-1:0]             rd_gen;
    logic [ADDR_WIDTH-1:0]            rd_addr;
    logic                             rd_valid;
    logic                             gen_match;
    logic                             slot_ok;
    logic                             handle_op;
    logic                             unpin_ok;

    ght_pkg::fm_ctrl_t                fm_ctrl;
    ght_pkg::fm_stat_t                fm_stat;
    logic [IDX_W-1:0]                 fm_idx;

    assign rd_gen    = ent_rd_reg[ENT_W-1:ADDR_WIDTH];
    assign rd_addr   = ent_rd_reg[ADDR_WIDTH-1:0];
    assign rd_valid  = (rd_addr != '0);
    assign gen_match = (hgen_reg == ght_pkg::GEN_PORT_W'(rd_gen));
    assign unpin_ok  = (kind_reg == ght_pkg::KIND_UNPIN) && gen_match && rd_valid;
    assign slot_ok   = (req.handle_slot != '0) && (req.handle_slot <= CNT_W'(CAPACITY));
    assign handle_op = (req.kind == ght_pkg::KIND_UNPIN) || (req.kind == ght_pkg::KIND_DEREF);

    assign rsp_load       = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);
    assign rsp_valid_next = rsp_load || (rsp_valid_reg && !rsp.ready);

    assign fm_ctrl.search = (state_reg == S_FM_START) && !fm_stat.busy;
    assign fm_ctrl.free   = (state_reg == S_LOOKUP) && unpin_ok;

    ght_free_map #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .HINT_W   (CNT_W)
    ) u_free_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fm_ctrl),
        .hint      (hint_reg),
        .free_idx  (idx_reg),
        .stat      (fm_stat),
        .found_idx (fm_idx)
    );

    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = idx_reg;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = {rd_gen, addr_in_reg};
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = {GEN_WIDTH'(1), {ADDR_WIDTH{1'b0}}};
            end
            S_IDLE:
            begin
                if (req.valid && handle_op && slot_ok)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = IDX_W'(req.handle_slot - CNT_W'(1));
                end
            end
            S_SEARCH:
            begin
                if (fm_stat.done && fm_stat.found)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = fm_idx;
                end
            end
            S_PIN_WR:
            begin
                mem_we = 1'b1;
            end
            S_LOOKUP:
            begin
                if (unpin_ok)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {rd_gen + GEN_WIDTH'(1), {ADDR_WIDTH{1'b0}}};
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ent_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            ent_rd_reg <= ent_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            hint_reg      <= '0;
            live_reg      <= '0;
            stale_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + IDX_W'(1);
                    if (clr_reg == IDX_W'(CAPACITY - 1))
                    begin
                        state_reg <= S_CLR_WAIT;
                    end
                end
                S_CLR_WAIT:
                begin
                    if (!fm_stat.busy)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        kind_reg     <= req.kind;
                        addr_in_reg  <= req.object_address;
                        hgen_reg     <= req.handle_generation;
                        idx_reg      <= IDX_W'(req.handle_slot - CNT_W'(1));
                        res_slot_reg <= '0;
                        res_gen_reg  <= '0;
                        res_addr_reg <= '0;
                        unique case (req.kind)
                            ght_pkg::KIND_PIN:
                            begin
                                if (req.object_address == '0)
                                begin
                                    res_status_reg <= ght_pkg::ST_FULL;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    res_status_reg <= ght_pkg::ST_OK;
                                    state_reg      <= S_FM_START;
                                end
                            end
                            ght_pkg::KIND_UNPIN, ght_pkg::KIND_DEREF:
                            begin
                                if (slot_ok)
                                begin
                                    res_status_reg <= ght_pkg::ST_OK;
                                    state_reg      <= S_LOOKUP;
                                end
                                else
                                begin
                                    res_status_reg <= ght_pkg::ST_BAD_INDEX;
                                    state_reg      <= S_DONE;
                                end
                            end
                            default:
                            begin
                                res_status_reg <= ght_pkg::ST_BAD_INDEX;
                                state_reg      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_FM_START:
                begin
                    if (!fm_stat.busy)
                    begin
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    if (fm_stat.done)
                    begin
                        if (fm_stat.found)
                        begin
                            idx_reg   <= fm_idx;
                            state_reg <= S_PIN_WR;
                        end
                        else
                        begin
                            res_status_reg <= ght_pkg::ST_FULL;
                            state_reg      <= S_DONE;
                        end
                    end
                end
                S_PIN_WR:
                begin
                    hint_reg     <= CNT_W'(idx_reg) + CNT_W'(1);
                    live_reg     <= live_reg + CNT_W'(1);
                    res_slot_reg <= CNT_W'(idx_reg) + CNT_W'(1);
                    res_gen_reg  <= ght_pkg::GEN_PORT_W'(rd_gen);
                    state_reg    <= S_DONE;
                end
                S_LOOKUP:
                begin
                    state_reg <= S_DONE;
                    if (kind_reg == ght_pkg::KIND_UNPIN)
                    begin
                        if (unpin_ok)
                        begin
                            if (CNT_W'(idx_reg) < hint_reg)
                            begin
                                hint_reg <= CNT_W'(idx_reg);
                            end
                            if (live_reg != '0)
                            begin
                                live_reg <= live_reg - CNT_W'(1);
                            end
                        end
                        else
                        begin
                            res_status_reg <= ght_pkg::ST_STALE;
                        end
                    end
                    else
                    begin
                        priority if (!gen_match)
                        begin
                            if (stale_reg != '1)
                            begin
                                stale_reg <= stale_reg + ght_pkg::VIOL_W'(1);
                            end
                            res_status_reg <= ght_pkg::ST_STALE;
                        end
                        else if (!rd_valid)
                        begin
                            res_status_reg <= ght_pkg::ST_STALE;
                        end
                        else
                        begin
                            res_addr_reg <= rd_addr;
                        end
                    end
                end
                S_DONE:
                begin
                    if (rsp_load)
                    begin
                        rsp_status_reg <= res_status_reg;
                        rsp_slot_reg   <= res_slot_reg;
                        rsp_gen_reg    <= res_gen_reg;
                        rsp_addr_reg   <= res_addr_reg;
                        rsp_live_reg   <= live_reg;
                        rsp_viol_reg   <= stale_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.out_slot        = rsp_slot_reg;
    assign rsp.out_generation  = rsp_gen_reg;
    assign rsp.out_address     = rsp_addr_reg;
    assign rsp.live_count      = rsp_live_reg;
    assign rsp.violation_count = rsp_viol_reg;

    `ASSERT_IMPLIES(a_live_bound, 1'b1, live_reg <= CNT_W'(CAPACITY))
    `ASSERT_IMPLIES(a_free_when_idle, fm_ctrl.free, !fm_stat.busy)
    `ASSERT_IMPLIES(a_found_in_range, fm_stat.found, CNT_W'(fm_idx) < CNT_W'(CAPACITY))
    `ASSERT_NEXT(a_hint_after_pin, state_reg == S_PIN_WR, hint_reg != '0)
    `ASSERT_NEXT(a_viol_monotonic, 1'b1, stale_reg >= $past(stale_reg))

endmodule

// File: tb/sv/tb_generational_handle_table_top.sv
// Self-checking testbench of the generational handle table with a shadow slot map.
module tb_generational_handle_table_top;

    localparam int CAPACITY     = 4096;
    localparam int SLOT_W       = 13;
    localparam int ADDR_W       = 32;
    localparam int SLOT_MAX     = (1 << SLOT_W) - 1;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int PHASE_WORDS  = 440;

    typedef struct packed {
        ght_pkg::kind_t                  kind;
        logic [ADDR_W-1:0]               address;
        logic [SLOT_W-1:0]               slot;
        logic [ght_pkg::GEN_PORT_W-1:0]  generation;
    } op_word_t;

    typedef struct packed {
        ght_pkg::status_t                status;
        logic [SLOT_W-1:0]               slot;
        logic [ght_pkg::GEN_PORT_W-1:0]  generation;
        logic [ADDR_W-1:0]               address;
        logic [SLOT_W-1:0]               live;
        logic [ght_pkg::VIOL_W-1:0]      violations;
    } reply_word_t;

    class slot_map_shadow;
        logic [ADDR_W-1:0]              slot_address [CAPACITY];
        bit                             slot_valid [CAPACITY];
        logic [ght_pkg::GEN_PORT_W-1:0] slot_generation [CAPACITY];
        int unsigned                    free_hint;
        int unsigned                    live_slots;
        logic [ght_pkg::VIOL_W-1:0]     stale_faults;
        int                             live_index [$];
        reply_word_t                    pending_replies [$];
        int unsigned                    mismatches;

        function new();
            for (int i = 0; i < CAPACITY; i++)
            begin
                slot_address[i]    = '0;
                slot_valid[i]      = 1'b0;
                slot_generation[i] = 1;
            end
            free_hint    = 0;
            live_slots   = 0;
            stale_faults = '0;
            mismatches   = 0;
        endfunction

        function void record_request(op_word_t w);
            reply_word_t r;
            int          found;
            int unsigned idx;
            int          pos [$];
            r = '0;
            found = -1;
            if (w.kind == ght_pkg::KIND_PIN)
            begin
                r.status = ght_pkg::ST_FULL;
                if (w.address != '0)
                begin
                    for (int i = free_hint; i < CAPACITY && found < 0; i++)
                        if (!slot_valid[i])
                            found = i;
                end
                if (found >= 0)
                begin
                    slot_valid[found]   = 1'b1;
                    slot_address[found] = w.address;
                    free_hint           = found + 1;
                    live_slots++;
                    live_index.push_back(found);
                    r.status     = ght_pkg::ST_OK;
                    r.slot       = SLOT_W'(found + 1);
                    r.generation = slot_generation[found];
                end
            end
            else if (w.kind == ght_pkg::KIND_BAD || w.slot == '0 || w.slot > CAPACITY)
                r.status = ght_pkg::ST_BAD_INDEX;
            else
            begin
                idx = w.slot - 1;
                r.status = ght_pkg::ST_STALE;
                if (w.kind == ght_pkg::KIND_UNPIN)
                begin
                    if (slot_generation[idx] == w.generation && slot_valid[idx])
                    begin
                        slot_valid[idx]      = 1'b0;
                        slot_address[idx]    = '0;
                        slot_generation[idx] = slot_generation[idx] + 1;
                        if (idx < free_hint)
                            free_hint = idx;
                        if (live_slots > 0)
                            live_slots--;
                        pos = live_index.find_first_index(x) with (x == idx);
                        live_index.delete(pos[0]);
                        r.status = ght_pkg::ST_OK;
                    end
                end
                else if (slot_generation[idx] != w.generation)
                begin
                    if (stale_faults != '1)
                        stale_faults++;
                end
                else if (slot_valid[idx])
                begin
                    r.status  = ght_pkg::ST_OK;
                    r.address = slot_address[idx];
                end
            end
            r.live       = SLOT_W'(live_slots);
            r.violations = stale_faults;
            pending_replies.push_back(r);
        endfunction

        function void check_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void compare_result(reply_word_t got);
            reply_word_t want;
            if (pending_replies.size() == 0)
            begin
                $error("result word arrived with no request outstanding");
                mismatches++;
                return;
            end
            want = pending_replies.pop_front();
            check_field("status", want.status, got.status);
            check_field("out_slot", want.slot, got.slot);
            check_field("out_generation", want.generation, got.generation);
            check_field("out_address", want.address, got.address);
            check_field("live_count", want.live, got.live);
            check_field("violation_count", want.violations, got.violations);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct = 0;
    int   reply_stall_pct = 0;
    int   cycle_count = 0;

    slot_map_shadow shadow;

    ght_req_if #(.ADDR_W(ADDR_W), .SLOT_W(SLOT_W)) req_ch ();
    ght_rsp_if #(.ADDR_W(ADDR_W), .SLOT_W(SLOT_W)) rsp_ch ();

    generational_handle_table_top #(
        .CAPACITY   (CAPACITY),
        .ADDR_WIDTH (ADDR_W),
        .GEN_WIDTH  (ght_pkg::GEN_PORT_W)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= reply_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            shadow.compare_result('{rsp_ch.status, rsp_ch.out_slot, rsp_ch.out_generation,
                                    rsp_ch.out_address, rsp_ch.live_count,
                                    rsp_ch.violation_count});
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("generational_handle_table_top regression: fail");
            $finish;
        end
    end

    function automatic op_word_t make_word(ght_pkg::kind_t k, logic [ADDR_W-1:0] a,
                                           logic [SLOT_W-1:0] s,
                                           logic [ght_pkg::GEN_PORT_W-1:0] g);
        op_word_t w;
        w.kind       = k;
        w.address    = a;
        w.slot       = s;
        w.generation = g;
        return w;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return '1;
        if (r == 1)
            return ADDR_W'(1) << $urandom_range(ADDR_W - 1);
        return $urandom;
    endfunction

    function automatic op_word_t random_operation();
        op_word_t                       w;
        int unsigned                    r;
        int unsigned                    idx;
        logic [ght_pkg::GEN_PORT_W-1:0] g;
        logic [ght_pkg::GEN_PORT_W-1:0] old_g;
        r = $urandom_range(99);
        w = make_word(ght_pkg::KIND_PIN, pick_address(), SLOT_W'($urandom), $urandom);
        if (r >= 40 && r < 84 && shadow.live_index.size() == 0)
            r = 0;
        if (r >= 40 && r < 84)
        begin
            idx = shadow.live_index[$urandom_range(shadow.live_index.size() - 1)];
            g = shadow.slot_generation[idx];
            if (r < 60)
                w = make_word(ght_pkg::KIND_UNPIN, $urandom, SLOT_W'(idx + 1), g);
            else if (r < 75)
                w = make_word(ght_pkg::KIND_DEREF, $urandom, SLOT_W'(idx + 1), g);
            else
            begin
                old_g = $urandom_range(1) ? g - 1 : $urandom;
                if (old_g == g)
                    old_g = ~g;
                w = make_word(r < 80 ? ght_pkg::KIND_DEREF : ght_pkg::KIND_UNPIN, $urandom,
                              SLOT_W'(idx + 1), old_g);
            end
        end
        else if (r >= 84 && r < 88)
        begin
            idx = $urandom_range(CAPACITY - 1);
            w = make_word(r < 86 ? ght_pkg::KIND_UNPIN : ght_pkg::KIND_DEREF, $urandom,
                          SLOT_W'(idx + 1), shadow.slot_generation[idx]);
        end
        else if (r >= 88 && r < 92)
            w = make_word(r < 90 ? ght_pkg::KIND_UNPIN : ght_pkg::KIND_DEREF, $urandom,
                          $urandom_range(1) ? '0 : SLOT_W'($urandom_range(CAPACITY + 1, SLOT_MAX)),
                          $urandom);
        else if (r >= 92 && r < 94)
            w = make_word(ght_pkg::KIND_BAD, $urandom, SLOT_W'($urandom), $urandom);
        else if (r >= 94 && r < 96)
            w.address = '0;
        else if (r >= 96)
            w = make_word(ght_pkg::kind_t'($urandom), $urandom, SLOT_W'($urandom), $urandom);
        return w;
    endfunction

    task automatic send_word(op_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid             <= 1'b1;
        req_ch.kind              <= w.kind;
        req_ch.object_address    <= w.address;
        req_ch.handle_slot       <= w.slot;
        req_ch.handle_generation <= w.generation;
        do
            @(posedge clk);
        while (!req_ch.ready);
        shadow.record_request(w);
        @(negedge clk);
    endtask

    task automatic run_random(int count);
        repeat (count)
            send_word(random_operation());
    endtask

    task automatic run_directed();
        send_word(make_word(ght_pkg::KIND_DEREF, '0, 1, 1));
        send_word(make_word(ght_pkg::KIND_UNPIN, '0, 1, 1));
        send_word(make_word(ght_pkg::KIND_PIN, '0, 1, 1));
        send_word(make_word(ght_pkg::KIND_PIN, '1, '1, '1));
        send_word(make_word(ght_pkg::KIND_PIN, 1, '0, '0));
        send_word(make_word(ght_pkg::KIND_DEREF, '0, 1, 1));
        send_word(make_word(ght_pkg::KIND_DEREF, '0, 1, '0));
        send_word(make_word(ght_pkg::KIND_DEREF, '1, 1, '1));
        send_word(make_word(ght_pkg::KIND_DEREF, '0, '0, 1));
        send_word(make_word(ght_pkg::KIND_DEREF, '0, SLOT_W'(CAPACITY + 1), 1));
        send_word(make_word(ght_pkg::KIND_DEREF, '0, '1, 1));
        send_word(make_word(ght_pkg::KIND_UNPIN, '0, '0, 1));
        send_word(make_word(ght_pkg::KIND_UNPIN, '0, '1, 1));
        send_word(make_word(ght_pkg::KIND_UNPIN, '0, 1, 2));
        send_word(make_word(ght_pkg::KIND_UNPIN, '0, 1, 1));
        send_word(make_word(ght_pkg::KIND_UNPIN, '0, 1, 1));
        send_word(make_word(ght_pkg::KIND_DEREF, '0, 1, 1));
        send_word(make_word(ght_pkg::KIND_DEREF, '0, 1, 2));
        send_word(make_word(ght_pkg::KIND_PIN, 32'h8000_0000, '0, '0));
        send_word(make_word(ght_pkg::KIND_PIN, 32'h5a5a_a5a5, '0, '0));
        send_word(make_word(ght_pkg::KIND_BAD, '1, '1, '1));
        send_word(make_word(ght_pkg::KIND_DEREF, '0, SLOT_W'(CAPACITY), 1));
        send_word(make_word(ght_pkg::KIND_UNPIN, '0, SLOT_W'(CAPACITY), 1));
        send_word(make_word(ght_pkg::KIND_DEREF, '0, 2, 1));
    endtask

    initial
    begin
        shadow = new();
        rst_n                    = 1'b0;
        req_ch.valid             = 1'b0;
        req_ch.kind              = ght_pkg::KIND_PIN;
        req_ch.object_address    = '0;
        req_ch.handle_slot       = '0;
        req_ch.handle_generation = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(PHASE_WORDS);
        send_idle_pct = 87;
        run_random(PHASE_WORDS);
        send_idle_pct   = 0;
        reply_stall_pct = 87;
        run_random(PHASE_WORDS);
        send_idle_pct   = 6;
        reply_stall_pct = 6;
        run_random(PHASE_WORDS);
        send_idle_pct   = 0;
        reply_stall_pct = 0;
        req_ch.valid <= 1'b0;

        while (shadow.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.pending_replies.size() == 0)
            $display("generational_handle_table_top regression: pass");
        else
            $display("generational_handle_table_top regression: fail");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ght_pkg.sv
rtl/core/ght_req_if.sv
rtl/core/ght_rsp_if.sv
rtl/core/ght_free_map.sv
rtl/core/generational_handle_table_top.sv
tb/sv/tb_generational_handle_table_top.sv
